// ----- rtl/utf32_to_koi8r_converter_macros.svh -----
// Assertion macros shared by the converter's checker.
`ifndef UTF32_TO_KOI8R_CONVERTER_MACROS_SVH
`define UTF32_TO_KOI8R_CONVERTER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define U2K_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication held from one edge to the next.
`define U2K_ASSERT_NEXT(label, cond, prop, msg) \
  `U2K_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ----- rtl/u2k_pkg.sv -----
// Shared types, constants and the KOI8-R table of the UTF-32 to KOI8-R converter.
package u2k_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] MARK_BE_AS_LE = 32'hFFFE_0000;
  localparam logic [7:0]  LEFT_BRACKET  = 8'h5B;
  localparam logic [7:0]  RIGHT_BRACKET = 8'h5D;
  localparam logic [7:0]  LINE_FEED     = 8'h0A;

  // Result kinds
  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_ESC   = 3'd1;
  localparam logic [2:0] KIND_BREAK = 3'd2;
  localparam logic [2:0] KIND_LE    = 3'd3;
  localparam logic [2:0] KIND_BE    = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_KOI_ENABLE      = 2'd0;
  localparam logic [1:0] REG_ESCAPE_BRACKETS = 2'd1;
  localparam logic [1:0] REG_ONE_PER_LINE    = 2'd2;
  localparam logic [1:0] REG_BYTE_ORDER_MODE = 2'd3;

  // Byte order modes
  localparam logic [1:0] ORDER_GUESS  = 2'd0;
  localparam logic [1:0] ORDER_LITTLE = 2'd1;

  typedef struct packed {
    logic       koi_enable;
    logic       escape_brackets;
    logic       one_per_line;
    logic [1:0] byte_order_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    ITEM_CHAR,
    ITEM_MARK_LE,
    ITEM_MARK_BE
  } item_kind_t;

  // One assembled group of four bytes, queued from front to back.
  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] cp;
    logic        koi_enable;
    logic        escape_brackets;
    logic        one_per_line;
  } item_t;

  localparam logic [15:0] KOI_TABLE [128] = '{
    16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
    16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
    16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
    16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
    16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
    16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
    16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
    16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
    16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
    16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
    16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
    16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
    16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
    16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
    16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
    16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
  };

endpackage

// ----- rtl/utf32_to_koi8r_converter.sv -----
// Top level of the UTF-32 to KOI8-R converter: configuration registers and front/back wiring.
//
// Takes a UTF-32 byte stream, one byte per transfer on the in_ channel, and
// gathers each four bytes into a code point. The front end accepts a byte every
// cycle; it only holds in_ready low on the fourth byte of a group while the
// four-entry queue towards the back end is full. With byte_order_mode 0 the first
// group is read as a byte-order mark, consumed, and reported as kind 3 (little
// endian) or kind 4 (big endian); modes 1 and 2 fix little or big endian, and
// mode 3 behaves as big endian. The back end looks the code point up in the
// 128-entry KOI8-R table with a parallel compare and registers one result per
// cycle: a plain byte (kind 0), an escape carrying the raw code point (kind 1),
// and, with one_per_line set, a line break (kind 2) after it.
// Sustained rate: one byte per cycle while the queue has room; each group
// yields one or two results. The result register is loaded whenever it is
// empty or being transferred, so the output stalls only for out_ready.
// Configuration writes take effect at the next byte and must only be made
// while the block is idle.
module utf32_to_koi8r_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] code_point,
  output logic        last
);
  import u2k_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  item_t head_item;
  logic  queue_empty;

  // Configuration registers; each write lands on the next rising edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.koi_enable      <= 1'b1;
      cfg.escape_brackets <= 1'b0;
      cfg.one_per_line    <= 1'b0;
      cfg.byte_order_mode <= ORDER_GUESS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KOI_ENABLE:      cfg.koi_enable      <= cfg_data[0];
        REG_ESCAPE_BRACKETS: cfg.escape_brackets <= cfg_data[0];
        REG_ONE_PER_LINE:    cfg.one_per_line    <= cfg_data[0];
        REG_BYTE_ORDER_MODE: cfg.byte_order_mode <= cfg_data;
        default:             cfg.koi_enable      <= cfg.koi_enable;
      endcase
    end
  end

  // Front end: assemble groups and resolve the byte order.
  u2k_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Decouple the two ends so each can stall on its own.
  u2k_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head_item (head_item),
    .empty     (queue_empty)
  );

  // Back end: table lookup, result formatting and the output register.
  u2k_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .code_point  (code_point),
    .last        (last)
  );

endmodule

// ----- rtl/u2k_front.sv -----
// Front end: accepts stream bytes, assembles groups of four and reads the byte-order mark.
module u2k_front (
  input  logic           clk,
  input  logic           rst,
  input  u2k_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           queue_full,
  output logic           push,
  output u2k_pkg::item_t push_item
);
  import u2k_pkg::*;

  logic [1:0]  byte_index;
  logic [31:0] code_accum;
  logic        guess_pending;
  logic        big_endian;

  logic        guessing;
  logic        be;
  logic        accept;
  logic [1:0]  slot;
  logic [4:0]  shift;
  logic [31:0] base;
  logic [31:0] code_next;
  logic        is_be_mark;

  // The group's final byte needs room in the queue; earlier bytes never stall.
  assign in_ready = (byte_index != 2'd3) || !queue_full;
  assign accept   = in_valid && in_ready;

  assign guessing = (cfg.byte_order_mode == ORDER_GUESS) && guess_pending;

  always_comb begin
    if (guessing) begin
      be = 1'b0;
    end else if (cfg.byte_order_mode == ORDER_GUESS) begin
      be = big_endian;
    end else begin
      be = (cfg.byte_order_mode != ORDER_LITTLE);
    end
  end

  assign slot       = be ? (2'd3 - byte_index) : byte_index;
  assign shift      = {slot, 3'b000};
  assign base       = (byte_index == 2'd0) ? 32'd0 : code_accum;
  assign code_next  = base + ({24'd0, in_byte} << shift);
  assign is_be_mark = (code_next == MARK_BE_AS_LE);

  assign push = accept && (byte_index == 2'd3);

  always_comb begin
    push_item.cp              = code_next;
    push_item.koi_enable      = cfg.koi_enable;
    push_item.escape_brackets = cfg.escape_brackets;
    push_item.one_per_line    = cfg.one_per_line;
    if (!guessing) begin
      push_item.kind = ITEM_CHAR;
    end else if (is_be_mark) begin
      push_item.kind = ITEM_MARK_BE;
    end else begin
      push_item.kind = ITEM_MARK_LE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= 2'd0;
      code_accum    <= 32'd0;
      guess_pending <= 1'b1;
      big_endian    <= 1'b0;
    end else if (accept) begin
      byte_index <= byte_index + 2'd1;
      code_accum <= code_next;
      if ((byte_index == 2'd3) && guessing) begin
        guess_pending <= 1'b0;
        big_endian    <= is_be_mark;
      end
    end
  end

endmodule

// ----- rtl/u2k_queue.sv -----
// Short queue of assembled groups between front and back end.
module u2k_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u2k_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output u2k_pkg::item_t head_item,
  output logic           empty
);
  import u2k_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

// ----- rtl/u2k_back.sv -----
// Back end: maps queued code points to results and drives the output register.
module u2k_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           queue_empty,
  input  u2k_pkg::item_t head_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     kind,
  output logic [7:0]     out_byte,
  output logic [31:0]    code_point,
  output logic           last
);
  import u2k_pkg::*;

  logic        pending_break;
  logic        slot_free;
  logic        load_break;
  logic        table_hit;
  logic [6:0]  table_index;
  logic        is_bracket;
  logic [2:0]  kind_next;
  logic [7:0]  byte_next;
  logic [31:0] cp_next;

  assign slot_free  = !out_valid || out_ready;
  assign load_break = slot_free && pending_break;
  assign pop        = slot_free && !pending_break && !queue_empty;

  // Entries are distinct, so OR-ing the matching indexes gives the one hit.
  always_comb begin
    table_hit   = 1'b0;
    table_index = 7'd0;
    for (int i = 0; i < 128; i++) begin
      if ((head_item.cp[31:16] == 16'd0) && (head_item.cp[15:0] == KOI_TABLE[i])) begin
        table_hit   = 1'b1;
        table_index = table_index | 7'(i);
      end
    end
  end

  assign is_bracket = (head_item.cp == {24'd0, LEFT_BRACKET}) ||
                      (head_item.cp == {24'd0, RIGHT_BRACKET});

  always_comb begin
    kind_next = KIND_ESC;
    byte_next = 8'd0;
    cp_next   = 32'd0;
    unique case (head_item.kind)
      ITEM_MARK_LE: kind_next = KIND_LE;
      ITEM_MARK_BE: kind_next = KIND_BE;
      ITEM_CHAR: begin
        priority if (head_item.koi_enable && (head_item.cp > 32'd128) && table_hit) begin
          kind_next = KIND_BYTE;
          byte_next = {1'b1, table_index};
        end else if ((head_item.cp < 32'd128) &&
                     !(head_item.escape_brackets && is_bracket)) begin
          kind_next = KIND_BYTE;
          byte_next = head_item.cp[7:0];
        end else begin
          kind_next = KIND_ESC;
          cp_next   = head_item.cp;
        end
      end
      default: kind_next = KIND_ESC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      pending_break <= 1'b0;
    end else begin
      if (load_break) begin
        out_valid     <= 1'b1;
        pending_break <= 1'b0;
      end else if (pop) begin
        out_valid     <= 1'b1;
        pending_break <= head_item.one_per_line;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_break) begin
      kind       <= KIND_BREAK;
      out_byte   <= LINE_FEED;
      code_point <= 32'd0;
      last       <= 1'b1;
    end else if (pop) begin
      kind       <= kind_next;
      out_byte   <= byte_next;
      code_point <= cp_next;
      last       <= !head_item.one_per_line;
    end
  end

endmodule

// ----- rtl/u2k_checker.sv -----
// Port-level checker for the converter, bound to the top level.
`include "utf32_to_koi8r_converter_macros.svh"

module u2k_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [7:0]  out_byte,
  input logic [31:0] code_point,
  input logic        last
);
  import u2k_pkg::*;

  `U2K_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `U2K_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(code_point) && $stable(kind), "stalled result changed")
  `U2K_ASSERT(a_cp_only_escape, (out_valid && (kind != KIND_ESC)) |-> (code_point == 32'd0), "code point set on a non-escape result")
  `U2K_ASSERT(a_break_last, (out_valid && (kind == KIND_BREAK)) |-> (last && (out_byte == LINE_FEED)), "line break not final or not a line feed")

endmodule

bind utf32_to_koi8r_converter u2k_checker u_checker (.*);

// ----- dv/koi8r_result_checker.sv -----
`timescale 1ns / 100ps
// Checker for the UTF-32 to KOI8-R converter: predicts each result from the byte stream and compares.
module koi8r_result_checker
  import u2k_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  out_byte,
  input  logic [31:0] code_point,
  input  logic        last,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  octet;
    logic [31:0] cp;
    logic        last;
  } conv_result_t;

  // Big-endian mark 00 00 FE FF as it reads when gathered little endian
  localparam logic [31:0] BE_MARK_READ_LE = 32'hFFFE_0000;

  // Upper half of KOI8-R: code point of bytes 0x80 to 0xFF
  localparam logic [15:0] KOI8R_UPPER [128] = '{
    16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
    16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
    16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
    16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
    16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
    16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
    16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
    16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
    16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
    16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
    16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
    16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
    16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
    16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
    16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
    16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
  };

  logic         koi_on;
  logic         esc_on;
  logic         lf_on;
  logic [1:0]   order_mode;
  logic [1:0]   byte_pos;
  logic [31:0]  accum;
  logic         mark_pending;
  logic         order_be;
  int           err_count;
  conv_result_t expected_results [$];
  conv_result_t got;
  conv_result_t want;

  function automatic int koi_slot(input logic [31:0] cp);
    for (int i = 0; i < 128; i++)
      if (cp == {16'h0000, KOI8R_UPPER[i]}) return i;
    return -1;
  endfunction

  task automatic predict_conversion(input logic [7:0] b);
    logic         reading_mark;
    logic         be;
    int           sh;
    int           slot;
    int           n;
    conv_result_t res [2];
    reading_mark = (order_mode == ORDER_GUESS) && mark_pending;
    if (reading_mark) be = 1'b0;
    else if (order_mode == ORDER_GUESS) be = order_be;
    else be = (order_mode != ORDER_LITTLE);
    sh = be ? 8 * (3 - int'(byte_pos)) : 8 * int'(byte_pos);
    if (byte_pos == 2'd0) accum = '0;
    accum = accum + (32'(b) << sh);
    if (byte_pos == 2'd3) begin
      if (reading_mark) begin
        mark_pending = 1'b0;
        order_be = (accum == BE_MARK_READ_LE);
        res[0] = '{order_be ? KIND_BE : KIND_LE, 8'h00, 32'h0, 1'b0};
      end else begin
        slot = (koi_on && accum > 32'd128) ? koi_slot(accum) : -1;
        if (slot >= 0)
          res[0] = '{KIND_BYTE, 8'(128 + slot), 32'h0, 1'b0};
        else if (accum < 32'd128 &&
                 !(esc_on && (accum == 32'(LEFT_BRACKET) || accum == 32'(RIGHT_BRACKET))))
          res[0] = '{KIND_BYTE, accum[7:0], 32'h0, 1'b0};
        else
          res[0] = '{KIND_ESC, 8'h00, accum, 1'b0};
      end
      n = 1;
      if (lf_on) begin
        res[1] = '{KIND_BREAK, LINE_FEED, 32'h0, 1'b0};
        n = 2;
      end
      res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
    end
    byte_pos = byte_pos + 2'd1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      koi_on       = 1'b1;
      esc_on       = 1'b0;
      lf_on        = 1'b0;
      order_mode   = ORDER_GUESS;
      byte_pos     = 2'd0;
      accum        = '0;
      mark_pending = 1'b1;
      order_be     = 1'b0;
      err_count    = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) predict_conversion(in_byte);
      if (out_valid && out_ready) begin
        got = '{kind, out_byte, code_point, last};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %h cp %h last %b",
                   $time, got.kind, got.octet, got.cp, got.last);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected kind %0d byte %h cp %h last %b, got kind %0d byte %h cp %h last %b",
                     $time, want.kind, want.octet, want.cp, want.last,
                     got.kind, got.octet, got.cp, got.last);
            err_count++;
          end
        end
      end
      // Writes land after any byte of the same edge
      if (cfg_write) begin
        case (cfg_index)
          REG_KOI_ENABLE:      koi_on = cfg_data[0];
          REG_ESCAPE_BRACKETS: esc_on = cfg_data[0];
          REG_ONE_PER_LINE:    lf_on = cfg_data[0];
          REG_BYTE_ORDER_MODE: order_mode = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches  <= err_count;
    outstanding <= expected_results.size();
  end

endmodule

// ----- dv/utf32_to_koi8r_converter_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the UTF-32 to KOI8-R converter: stimulus, stalls and verdict.
module utf32_to_koi8r_converter_tb;
  import u2k_pkg::*;

  // Mode codes the package leaves unnamed
  localparam logic [1:0] ORDER_BIG   = 2'd2;
  localparam logic [1:0] ORDER_SPARE = 2'd3;

  localparam int PHASES       = 14;
  localparam int PHASE_BYTES  = 125;
  localparam int QUIET_PHASES = 2;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] code_point;
  logic        last;
  int          mismatches;
  int          outstanding;

  // Stimulus bookkeeping: the order the stream is written in, and where we are in a group
  logic [1:0]  cur_mode = ORDER_GUESS;
  logic        mark_sent = 1'b0;
  logic        guessed_be = 1'b0;
  logic [1:0]  sent_pos = 2'd0;
  logic        idle_on = 1'b1;
  int          phase_bytes = 0;
  int          stall_left = 0;
  int          cycle_count = 0;

  utf32_to_koi8r_converter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .code_point (code_point),
    .last       (last)
  );

  koi8r_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_byte    (out_byte),
    .code_point  (code_point),
    .last        (last),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: drop out_ready in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Byte order the block will apply to the next group
  function automatic logic stream_be();
    if (cur_mode == ORDER_GUESS) return mark_sent ? guessed_be : 1'b0;
    return cur_mode != ORDER_LITTLE;
  endfunction

  // Mostly code points that exercise a particular path, some wholly random
  function automatic logic [31:0] rand_code_point();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($urandom_range(0, 127));
      3:       return $urandom_range(0, 1) ? 32'(LEFT_BRACKET) : 32'(RIGHT_BRACKET);
      4, 5, 6: return {16'h0000, KOI_TABLE[$urandom_range(0, 127)]};
      7:       return 32'($urandom_range(126, 130));
      8:       return 32'($urandom_range(0, 16'hFFFF));
      default: return $urandom;
    endcase
  endfunction

  // Write every register; call only with the block idle
  task automatic write_settings(input logic koi, input logic esc, input logic opl,
                                input logic [1:0] mode);
    cfg_write <= 1'b1;
    cfg_index <= REG_KOI_ENABLE;
    cfg_data  <= {1'b0, koi};
    @(posedge clk);
    cfg_index <= REG_ESCAPE_BRACKETS;
    cfg_data  <= {1'b0, esc};
    @(posedge clk);
    cfg_index <= REG_ONE_PER_LINE;
    cfg_data  <= {1'b0, opl};
    @(posedge clk);
    cfg_index <= REG_BYTE_ORDER_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_mode = mode;
  endtask

  // Offer one byte, with an optional gap first, and hold it until the transfer
  task automatic push_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_pos = sent_pos + 2'd1;
    phase_bytes++;
  endtask

  // Send a code point as a whole group; finish off a broken group with noise first
  task automatic push_char(input logic [31:0] cp);
    logic be;
    while (sent_pos != 2'd0) push_byte(8'($urandom_range(0, 255)));
    be = stream_be();
    for (int i = 0; i < 4; i++)
      push_byte(be ? cp[8*(3-i) +: 8] : cp[8*i +: 8]);
  endtask

  // Hold off the sender until every expected result is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fixed big endian with escaping and line breaks: escaped bracket, last table entry
    write_settings(1'b1, 1'b1, 1'b1, ORDER_BIG);
    push_char(32'h0000_005B);
    push_char(32'h0000_042A);

    // Little endian, table off: raw bracket, code point 128, all ones
    drain();
    write_settings(1'b0, 1'b0, 1'b0, ORDER_LITTLE);
    push_char(32'h0000_005D);
    push_char(32'h0000_0080);
    push_char(32'hFFFF_FFFF);

    // The spare mode acts as big endian: first table entry, then half a group
    drain();
    write_settings(1'b1, 1'b0, 1'b1, ORDER_SPARE);
    push_char(32'h0000_2500);
    push_byte(8'h01);
    push_byte(8'h02);

    // Switch order mid-group: the second half lands little endian
    drain();
    write_settings(1'b1, 1'b0, 1'b1, ORDER_LITTLE);
    push_byte(8'h03);
    push_byte(8'h04);

    // Back to guessing with no mark read yet: the next group is the mark
    drain();
    write_settings(1'b1, 1'b1, 1'b0, ORDER_GUESS);
    guessed_be = 1'($urandom_range(0, 1));
    if (guessed_be) begin
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'hFE);
      push_byte(8'hFF);
    end else begin
      push_byte(8'hFF);
      push_byte(8'hFE);
      push_byte(8'h00);
      push_byte(8'h00);
    end
    mark_sent = 1'b1;
    push_char(32'h0000_007F);
    push_char(32'h0000_0000);

    // Random phases, each under its own settings; the first two take the extremes
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == 0)
        write_settings(1'b0, 1'b0, 1'b0, ORDER_GUESS);
      else if (phase == 1)
        write_settings(1'b1, 1'b1, 1'b1, ORDER_BIG);
      else
        write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      // Run flat out at the end
      if (phase >= PHASES - QUIET_PHASES) idle_on = 1'b0;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if ($urandom_range(0, 6) != 0)
          push_char(rand_code_point());
        else
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
    end

    drain();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
